FILE: hdl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg: shared definitions for the triangle enumerator
// Node and row widths, input kind codes, the controller/datapath command and
// status bundles, and small bit-vector helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = 5;
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int ROW_W     = 32;
   localparam int COUNT_W   = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(32);
   localparam logic [0:0] CSR_NODE_COUNT = 1'b0;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   typedef struct packed {
      logic load;
      logic start;
      logic read_u;
      logic latch_u;
      logic pick_v;
      logic step_u;
      logic take_hit;
      logic take_miss;
   } gte_cmd_type;

   typedef struct packed {
      logic u_done;
      logic cand_empty;
      logic hit;
   } gte_stat_type;

   function automatic logic [NODE_W-1:0] low_index(input logic [ROW_W-1:0] x);
      logic [NODE_W-1:0] r;
      r = '0;
      for (int j = ROW_W - 1; j >= 0; j--) begin
         if (x[j]) begin
            r = NODE_W'(j);
         end
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] mask_from(input logic [CNT_W-1:0] lo);
      logic [ROW_W-1:0] m;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (j >= int'(lo));
      end
      return m;
   endfunction

   function automatic logic [ROW_W-1:0] mask_below(input logic [CNT_W-1:0] hi);
      logic [ROW_W-1:0] m;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (j < int'(hi));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/gte_ctrl.sv
// ----------------------------------------------------------------------------
// gte_ctrl: sequencer for the triangle enumerator
// Walks the first node, picks candidate middle nodes and tests each one
// against the datapath, then hands a result to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire gte_pkg::gte_stat_type stat,
   output gte_pkg::gte_cmd_type       cmd
);
   import gte_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_U,
      S_LOAD_U,
      S_PICK_V,
      S_EVAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      fin_ok;

   assign fin_ok    = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_READ_U;
               end
            end
         end
         S_READ_U: begin
            if (stat.u_done) begin
               if (fin_ok) begin
                  cmd.take_miss = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.read_u = 1'b1;
               state_in   = S_LOAD_U;
            end
         end
         S_LOAD_U: begin
            cmd.latch_u = 1'b1;
            state_in    = S_PICK_V;
         end
         S_PICK_V: begin
            if (stat.cand_empty) begin
               cmd.step_u = 1'b1;
               state_in   = S_READ_U;
            end else begin
               cmd.pick_v = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.hit) begin
               if (fin_ok) begin
                  cmd.take_hit = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_PICK_V;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.take_hit || cmd.take_miss) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gte_dp.sv
// ----------------------------------------------------------------------------
// gte_dp: datapath of the triangle enumerator
// Holds the adjacency row memory, the enumeration cursor, the scan registers
// for the current first node and candidate set, and the response fields.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gte_pkg::gte_cmd_type          cmd,
   output gte_pkg::gte_stat_type              stat,
   input  wire logic [gte_pkg::NODE_W-1:0]    req_row_index,
   input  wire logic [gte_pkg::ROW_W-1:0]     req_row_bits,
   input  wire logic [gte_pkg::COUNT_W-1:0]   node_count,
   output logic      [gte_pkg::NODE_W-1:0]    rsp_first_node,
   output logic      [gte_pkg::NODE_W-1:0]    rsp_second_node,
   output logic      [gte_pkg::NODE_W-1:0]    rsp_third_node,
   output logic                               rsp_found
);
   import gte_pkg::*;

   logic [ROW_W-1:0]     mem [MAX_NODES];
   logic [MAX_NODES-1:0] vld_ff;
   logic [ROW_W-1:0]     rd_row_ff;
   logic                 rd_vld_ff;
   logic [ROW_W-1:0]     rd_row;
   logic [NODE_W-1:0]    rd_addr;

   logic [CNT_W-1:0]     cur_low_ff;
   logic [CNT_W-1:0]     cur_mid_ff;
   logic [CNT_W-1:0]     cur_high_ff;

   logic [CNT_W-1:0]     u_ff;
   logic                 first_ff;
   logic [ROW_W-1:0]     rowu_ff;
   logic [ROW_W-1:0]     cand_ff;
   logic [NODE_W-1:0]    v_ff;

   logic [NODE_W-1:0]    first_node_ff;
   logic [NODE_W-1:0]    second_node_ff;
   logic [NODE_W-1:0]    third_node_ff;
   logic                 found_ff;

   logic [CNT_W-1:0]     n_eff;
   logic [ROW_W-1:0]     rowu_in;
   logic [CNT_W-1:0]     u_next;
   logic [CNT_W-1:0]     v_start;
   logic [CNT_W-1:0]     v_ext;
   logic [CNT_W-1:0]     v_next;
   logic [CNT_W-1:0]     w_start;
   logic [ROW_W-1:0]     hit_mask;
   logic [NODE_W-1:0]    w_sel;
   logic [NODE_W-1:0]    v_sel;

   assign n_eff = (CNT_W'(node_count) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(node_count);

   assign rd_row  = rd_vld_ff ? rd_row_ff : '0;
   assign v_sel   = low_index(cand_ff);
   assign rd_addr = cmd.pick_v ? v_sel : u_ff[NODE_W-1:0];

   assign rowu_in = rd_row & mask_below(n_eff);
   assign u_next  = u_ff + CNT_W'(1);
   assign v_start = (first_ff && (cur_mid_ff > u_next)) ? cur_mid_ff : u_next;

   assign v_ext   = CNT_W'(v_ff);
   assign v_next  = v_ext + CNT_W'(1);
   assign w_start = (first_ff && (v_ext == cur_mid_ff) && (cur_high_ff > v_next))
                    ? cur_high_ff : v_next;
   assign hit_mask = rd_row & rowu_ff & mask_from(w_start);
   assign w_sel    = low_index(hit_mask);

   assign stat.u_done     = (u_ff >= n_eff);
   assign stat.cand_empty = (cand_ff == '0);
   assign stat.hit        = (hit_mask != '0);

   always_ff @(posedge clock) begin
      if (cmd.load && (CNT_W'(req_row_index) < CNT_W'(MAX_NODES))) begin
         mem[req_row_index] <= req_row_bits;
      end
      if (cmd.read_u || cmd.pick_v) begin
         rd_row_ff <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         cur_low_ff  <= '0;
         cur_mid_ff  <= '0;
         cur_high_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (CNT_W'(req_row_index) < CNT_W'(MAX_NODES)) begin
               vld_ff[req_row_index] <= 1'b1;
            end
            cur_low_ff  <= '0;
            cur_mid_ff  <= '0;
            cur_high_ff <= '0;
         end else if (cmd.take_hit) begin
            cur_low_ff  <= u_ff;
            cur_mid_ff  <= v_ext;
            cur_high_ff <= CNT_W'(w_sel) + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         u_ff     <= cur_low_ff;
         first_ff <= 1'b1;
      end else if (cmd.step_u) begin
         u_ff     <= u_next;
         first_ff <= 1'b0;
      end
      if (cmd.latch_u) begin
         rowu_ff <= rowu_in;
         cand_ff <= rowu_in & mask_from(v_start);
      end else if (cmd.pick_v) begin
         v_ff    <= v_sel;
         cand_ff <= cand_ff & (cand_ff - ROW_W'(1));
      end
      if (cmd.take_hit) begin
         first_node_ff  <= u_ff[NODE_W-1:0];
         second_node_ff <= v_ff;
         third_node_ff  <= w_sel;
         found_ff       <= 1'b1;
      end else if (cmd.take_miss) begin
         first_node_ff  <= '0;
         second_node_ff <= '0;
         third_node_ff  <= '0;
         found_ff       <= 1'b0;
      end
   end

   assign rsp_first_node  = first_node_ff;
   assign rsp_second_node = second_node_ff;
   assign rsp_third_node  = third_node_ff;
   assign rsp_found       = found_ff;

endmodule

`default_nettype wire

FILE: hdl/graph_triangle_enumerator.sv
// Sequence: a row load is taken straight from idle. A fetch runs a start step,
// then per first node a row read, a row latch and a candidate pick (no final pick
// for the node holding the hit), per candidate middle node a pick and a test, and a closing step on a not-found.
// Throughput: one transaction at a time; the single read port of the row
// memory, read once per first node and once per candidate, sets the pace.
// Reset: synchronous; row valid bits, cursor and controller clear, node count 32.
// ----------------------------------------------------------------------------
// graph_triangle_enumerator: triangle listing over an adjacency bit matrix
// Loads adjacency rows and returns the next triangle on each fetch, with the
// node count held in a register behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_triangle_enumerator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [gte_pkg::NODE_W-1:0]        req_row_index,
   input  wire logic [gte_pkg::ROW_W-1:0]         req_row_bits,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [gte_pkg::NODE_W-1:0]        rsp_first_node,
   output logic      [gte_pkg::NODE_W-1:0]        rsp_second_node,
   output logic      [gte_pkg::NODE_W-1:0]        rsp_third_node,
   output logic                                   rsp_found,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [gte_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [gte_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [gte_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);
   import gte_pkg::*;

   logic [COUNT_W-1:0] node_count_ff;
   gte_cmd_type        cmd;
   gte_stat_type       stat;
   logic               csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[CSR_ADDR_W-1] == CSR_NODE_COUNT);
   assign prdata  = csr_sel ? CSR_DATA_W'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel) begin
         node_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   gte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gte_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .node_count      (node_count_ff),
      .rsp_first_node  (rsp_first_node),
      .rsp_second_node (rsp_second_node),
      .rsp_third_node  (rsp_third_node),
      .rsp_found       (rsp_found)
   );

endmodule

`default_nettype wire

FILE: hdl/gte_checker.sv
// ----------------------------------------------------------------------------
// gte_checker: port-level checks for the triangle enumerator
// Watches the request and response channels and flags ordering, stability
// and result-content violations.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_kind,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [gte_pkg::NODE_W-1:0]  rsp_first_node,
   input wire logic [gte_pkg::NODE_W-1:0]  rsp_second_node,
   input wire logic [gte_pkg::NODE_W-1:0]  rsp_third_node,
   input wire logic                        rsp_found
);
   import gte_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_node)
         && $stable(rsp_second_node) && $stable(rsp_third_node) && $stable(rsp_found))
      else $error("Response changed while stalled.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_first_node == '0 && rsp_second_node == '0
         && rsp_third_node == '0)
      else $error("Not-found response carries nonzero nodes.");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_first_node < rsp_second_node
         && rsp_second_node < rsp_third_node)
      else $error("Triangle nodes are not in ascending order.");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("Row load transaction produced a response.");

endmodule

bind graph_triangle_enumerator gte_checker u_gte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_first_node  (rsp_first_node),
   .rsp_second_node (rsp_second_node),
   .rsp_third_node  (rsp_third_node),
   .rsp_found       (rsp_found)
);

`default_nettype wire

FILE: tb/sv/tb_graph_triangle_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_triangle_enumerator: self-checking testbench for the enumerator
// Loads adjacency rows and fetches triangles through valid/ready channels,
// predicts every fetch result from a local copy of the matrix, cursor and
// node count, and compares each result transaction field by field. Node
// count writes go through the APB-style port between phases.
// ----------------------------------------------------------------------------

module tb_graph_triangle_enumerator;
   import gte_pkg::*;

   localparam int ITEM_TARGET   = 1150;
   localparam int QUIET_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 40;
   localparam int FETCH_CAP     = 40;
   localparam logic [CSR_ADDR_W-1:0] NODE_COUNT_ADDR = CSR_ADDR_W'({CSR_NODE_COUNT, 2'b00});

   typedef struct packed {
      logic [NODE_W-1:0] lo_node;
      logic [NODE_W-1:0] mid_node;
      logic [NODE_W-1:0] hi_node;
      logic              found;
   } triangle_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_kind;
   logic [NODE_W-1:0]     req_row_index;
   logic [ROW_W-1:0]      req_row_bits;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [NODE_W-1:0]     rsp_first_node;
   logic [NODE_W-1:0]     rsp_second_node;
   logic [NODE_W-1:0]     rsp_third_node;
   logic                  rsp_found;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [ROW_W-1:0]   adj_rows [MAX_NODES];
   int                 cursor_u;
   int                 cursor_v;
   int                 cursor_w;
   logic [COUNT_W-1:0] node_count_q;
   logic               predicted_found;
   triangle_type       expected_q [$];

   bit quiet;
   int items_sent;
   int loads_sent;
   int fetches_sent;
   int csr_writes;
   int results_seen;
   int triangles_seen;
   int error_count;

   graph_triangle_enumerator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_first_node  (rsp_first_node),
      .rsp_second_node (rsp_second_node),
      .rsp_third_node  (rsp_third_node),
      .rsp_found       (rsp_found),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, got_v);
      error_count++;
   endtask

   // Walks the candidates from the saved cursor onward and returns the next
   // triangle, or a cleared not-found result with the cursor left in place.
   function automatic triangle_type next_triangle();
      triangle_type t;
      int n;
      int v_start;
      int w_start;
      t = '0;
      n = (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
      for (int u = cursor_u; u < n; u++) begin
         v_start = u + 1;
         if (u == cursor_u && cursor_v > v_start) v_start = cursor_v;
         for (int v = v_start; v < n; v++) begin
            if (adj_rows[u][v]) begin
               w_start = v + 1;
               if (u == cursor_u && v == cursor_v && cursor_w > w_start) w_start = cursor_w;
               for (int w = w_start; w < n; w++) begin
                  if (adj_rows[v][w] && adj_rows[u][w]) begin
                     cursor_u = u;
                     cursor_v = v;
                     cursor_w = w + 1;
                     t.lo_node  = NODE_W'(u);
                     t.mid_node = NODE_W'(v);
                     t.hi_node  = NODE_W'(w);
                     t.found    = 1'b1;
                     return t;
                  end
               end
            end
         end
      end
      return t;
   endfunction

   task automatic send_item(input kind_type kind, input logic [NODE_W-1:0] idx,
                            input logic [ROW_W-1:0] bits);
      triangle_type t;
      quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_row_index <= idx;
      req_row_bits  <= bits;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == KIND_LOAD) begin
         adj_rows[idx] = bits;
         cursor_u = 0;
         cursor_v = 0;
         cursor_w = 0;
         loads_sent++;
      end else begin
         t = next_triangle();
         predicted_found = t.found;
         expected_q.insert(expected_q.size(), t);
         fetches_sent++;
      end
   endtask

   task automatic fetch_next();
      send_item(KIND_FETCH, NODE_W'($urandom_range(0, 31)), $urandom);
   endtask

   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= NODE_COUNT_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_node_count(input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] rd;
      wait_drained(SETTLE_CYCLES);
      csr_access(1'b1, ($urandom & ~32'h3F) | CSR_DATA_W'(count), rd);
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(count)) report_mismatch("node_count readback", count, rd);
      node_count_q = count;
      csr_writes++;
   endtask

   task automatic test_empty_graph();
      fetch_next();
   endtask

   task automatic test_complete_graph();
      set_node_count(COUNT_W'(4));
      for (int r = 0; r < 4; r++) send_item(KIND_LOAD, NODE_W'(r), '1);
      repeat (6) fetch_next();
   endtask

   task automatic test_resume_after_growth();
      set_node_count(COUNT_W'(5));
      repeat (3) fetch_next();
   endtask

   task automatic test_load_clears_cursor();
      send_item(KIND_LOAD, NODE_W'(31), '0);
      fetch_next();
      send_item(KIND_LOAD, NODE_W'(1), ROW_W'(1));
      fetch_next();
   endtask

   task automatic test_node_count_limits();
      set_node_count(COUNT_W'(0));
      fetch_next();
      set_node_count(COUNT_W'(63));
      fetch_next();
      set_node_count(COUNT_W'(2));
      fetch_next();
      set_node_count(COUNT_W'(3));
      fetch_next();
      set_node_count(COUNT_W'(32));
      fetch_next();
   endtask

   function automatic logic [COUNT_W-1:0] pick_node_count();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return COUNT_W'($urandom_range(3, 10));
      if (sel == 6) return COUNT_W'(32);
      if (sel == 7) return COUNT_W'($urandom_range(33, 63));
      if (sel == 8) return COUNT_W'($urandom_range(11, 31));
      return COUNT_W'($urandom_range(0, 2));
   endfunction

   function automatic logic [ROW_W-1:0] random_row(input int density);
      case (density)
         0: begin
            return $urandom | $urandom;
         end
         1: begin
            return $urandom;
         end
         default: begin
            return $urandom & $urandom & $urandom;
         end
      endcase
   endfunction

   task automatic load_random_graph();
      int n_eff;
      int density;
      n_eff = (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
      density = $urandom_range(0, 2);
      if (n_eff <= 12 && $urandom_range(0, 5) != 0) begin
         for (int r = 0; r < n_eff; r++) send_item(KIND_LOAD, NODE_W'(r), random_row(density));
         if (n_eff == 0) send_item(KIND_LOAD, NODE_W'($urandom_range(0, 31)), $urandom);
      end else begin
         repeat (8) begin
            send_item(KIND_LOAD, NODE_W'($urandom_range(0, 31)), random_row(density));
         end
      end
   endtask

   task automatic enumerate_triangles();
      int extra;
      int count;
      bit exhausted;
      if ($urandom_range(0, 9) == 0) wait_drained(0);
      extra = $urandom_range(0, 2);
      count = 0;
      exhausted = 1'b0;
      while (!(exhausted && extra == 0) && count < FETCH_CAP && items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(KIND_LOAD, NODE_W'($urandom_range(0, 31)), $urandom);
         end
         fetch_next();
         if (exhausted) extra--;
         else if (!predicted_found) exhausted = 1'b1;
         count++;
      end
   endtask

   task automatic test_random_graphs();
      while (items_sent < ITEM_TARGET) begin
         set_node_count(pick_node_count());
         repeat ($urandom_range(1, 4)) begin
            if (items_sent < ITEM_TARGET) begin
               load_random_graph();
               enumerate_triangles();
            end
         end
      end
   endtask

   always @(posedge clock) begin
      triangle_type exp_t;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_found) triangles_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending, found", 0, rsp_found);
         end else begin
            exp_t = expected_q.pop_front();
            if (rsp_first_node !== exp_t.lo_node)
               report_mismatch("first_node", exp_t.lo_node, rsp_first_node);
            if (rsp_second_node !== exp_t.mid_node)
               report_mismatch("second_node", exp_t.mid_node, rsp_second_node);
            if (rsp_third_node !== exp_t.hi_node)
               report_mismatch("third_node", exp_t.hi_node, rsp_third_node);
            if (rsp_found !== exp_t.found)
               report_mismatch("found", exp_t.found, rsp_found);
         end
      end
   end

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_kind      <= KIND_LOAD;
      req_row_index <= '0;
      req_row_bits  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      for (int r = 0; r < MAX_NODES; r++) adj_rows[r] = '0;
      cursor_u = 0;
      cursor_v = 0;
      cursor_w = 0;
      node_count_q = NODE_COUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_graph();
      test_complete_graph();
      test_resume_after_growth();
      test_load_clears_cursor();
      test_node_count_limits();
      test_random_graphs();

      wait_drained(SETTLE_CYCLES);
      $display("Sent %0d transactions (%0d row loads, %0d fetches), %0d node count writes.",
               items_sent, loads_sent, fetches_sent, csr_writes);
      $display("Checked %0d results, %0d of them triangles and the rest exhausted lists.",
               results_seen, triangles_seen);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/gte_pkg.sv
hdl/gte_ctrl.sv
hdl/gte_dp.sv
hdl/graph_triangle_enumerator.sv
hdl/gte_checker.sv
tb/sv/tb_graph_triangle_enumerator.sv
